// File: hdl/perspective_project_with_cull_macros.svh
// ----------------------------------------------------------------------------
// perspective_project_with_cull_macros
// Assertion helpers for the perspective projection block.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_PROJECT_WITH_CULL_MACROS_SVH
`define PERSPECTIVE_PROJECT_WITH_CULL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and constants shared by the perspective projection pipeline.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int QUOT_W = 32;
    localparam int NUM_W  = 2 * QUOT_W;

    localparam logic [31:0] CLAMP_QUOT = 32'h7FFF_FF00;

    localparam logic [1:0] CULL_NONE = 2'd0;
    localparam logic [1:0] CULL_X    = 2'd1;
    localparam logic [1:0] CULL_Y    = 2'd2;

    localparam logic [2:0] REG_HALF_PERSP   = 3'd0;
    localparam logic [2:0] REG_PERSP_SHIFT  = 3'd1;
    localparam logic [2:0] REG_HALF_WIDTH   = 3'd2;
    localparam logic [2:0] REG_HEIGHT       = 3'd3;
    localparam logic [2:0] REG_HALF_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_Y_SHIFT      = 3'd5;

    typedef struct packed {
        logic [1:0]  code;
        logic [15:0] angle;
    } side_t;

    typedef struct packed {
        logic [1:0]  code;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] angle;
    } result_t;

endpackage

// File: hdl/ppc_div_lane.sv
// ----------------------------------------------------------------------------
// ppc_div_lane
// Pipelined restoring divider for one axis: one quotient bit per stage.
// ----------------------------------------------------------------------------
module ppc_div_lane
    import ppc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [NUM_W-1:0]    num,
    input  logic [QUOT_W-1:0]   den,
    input  logic                neg,
    output logic [QUOT_W-1:0]   quot,
    output logic                clamp,
    output logic                neg_out
);

    logic [QUOT_W-1:0] rem_reg   [0:QUOT_W];
    logic [QUOT_W-1:0] lo_reg    [0:QUOT_W];
    logic [QUOT_W-1:0] quo_reg   [0:QUOT_W];
    logic [QUOT_W-1:0] den_reg   [0:QUOT_W];
    logic              neg_reg   [0:QUOT_W];
    logic              clamp_reg [1:QUOT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NUM_W-1:QUOT_W];
            lo_reg[0]  <= num[QUOT_W-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic [QUOT_W:0]   trial;
        logic [QUOT_W:0]   diff;
        logic              ge;
        logic [QUOT_W-1:0] rem_next;

        assign trial    = {rem_reg[k], lo_reg[k][QUOT_W-1]};
        assign diff     = trial - {1'b0, den_reg[k]};
        assign ge       = trial >= {1'b0, den_reg[k]};
        assign rem_next = ge ? diff[QUOT_W-1:0] : trial[QUOT_W-1:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                lo_reg[k+1]  <= {lo_reg[k][QUOT_W-2:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][QUOT_W-2:0], ge};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end

        // The quotient only fits in 32 bits when the high word is below the divisor.
        if (k == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    clamp_reg[1] <= rem_reg[0] >= den_reg[0];
                end
            end
        end else begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    clamp_reg[k+1] <= clamp_reg[k];
                end
            end
        end
    end

    assign quot    = quo_reg[QUOT_W];
    assign clamp   = clamp_reg[QUOT_W];
    assign neg_out = neg_reg[QUOT_W];

endmodule

// File: hdl/perspective_project_with_cull.sv
// ----------------------------------------------------------------------------
// perspective_project_with_cull
// Frustum cull and perspective divide of eye-space points to screen space.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     eye_x, eye_y, eye_z, rotation_angle, tile_index
//  out      out_valid / out_stall   cull_code, screen_x, screen_y, angle_out, tile_out
//  cfg      cfg_we                  cfg_index, cfg_data
//
// One item per cycle while in_stall is low; accepted items flow through the divider.
// The depth is set by the 32 quotient bits, one restoring step per stage.
// A two-entry output buffer lets the pipeline keep loading while out_stall is high;
// in_stall rises only when both entries hold items.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "perspective_project_with_cull_macros.svh"

module perspective_project_with_cull
    import ppc_pkg::*;
#(
    parameter int TILE_COUNT = 64,
    localparam int TILE_W = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic [15:0]        rotation_angle,
    input  logic [TILE_W-1:0]  tile_index,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         cull_code,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic [15:0]        angle_out,
    output logic [TILE_W-1:0]  tile_out
);

    localparam int LAST = QUOT_W;

    // Configuration registers.
    logic [31:0] half_persp_reg;
    logic [4:0]  persp_shift_reg;
    logic [14:0] half_width_reg;
    logic [14:0] height_reg;
    logic [14:0] half_height_reg;
    logic [15:0] y_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_persp_reg  <= '0;
            persp_shift_reg <= 5'd8;
            half_width_reg  <= 15'd160;
            height_reg      <= 15'd200;
            half_height_reg <= 15'd100;
            y_shift_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_PERSP:  half_persp_reg  <= cfg_data;
                REG_PERSP_SHIFT: persp_shift_reg <= cfg_data[4:0];
                REG_HALF_WIDTH:  half_width_reg  <= cfg_data[14:0];
                REG_HEIGHT:      height_reg      <= cfg_data[14:0];
                REG_HALF_HEIGHT: half_height_reg <= cfg_data[14:0];
                REG_Y_SHIFT:     y_shift_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Front end: magnitudes, cull decision and numerators.
    logic [31:0]      mag_x;
    logic [31:0]      mag_y;
    logic [1:0]       code_in;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic             pipe_en;

    assign mag_x = eye_x[31] ? (32'd0 - eye_x) : eye_x;
    assign mag_y = eye_y[31] ? (32'd0 - eye_y) : eye_y;

    // A wrapped most-negative magnitude reads as negative and so never culls.
    always_comb
    begin
        if ($signed(mag_x) > eye_z)
            code_in = CULL_X;
        else if ($signed(mag_y) > eye_z)
            code_in = CULL_Y;
        else
            code_in = CULL_NONE;
    end

    assign num_x = {32'd0, half_persp_reg} + ({32'd0, mag_x} << persp_shift_reg);
    assign num_y = {32'd0, half_persp_reg} + ({32'd0, mag_y} << persp_shift_reg);

    // Pipeline control and side data.
    logic                 skid_valid_reg;
    logic                 out_valid_reg;
    logic                 vld_reg  [0:LAST];
    side_t                side_reg [0:LAST];
    logic [TILE_W-1:0]    tile_reg [0:LAST];

    assign pipe_en  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (pipe_en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= LAST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side_reg[0] <= '{code: code_in, angle: rotation_angle};
            tile_reg[0] <= tile_index;
            for (int i = 1; i <= LAST; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                tile_reg[i] <= tile_reg[i-1];
            end
        end
    end

    logic [QUOT_W-1:0] quot_x;
    logic [QUOT_W-1:0] quot_y;
    logic              clamp_x;
    logic              clamp_y;
    logic              neg_x;
    logic              neg_y;

    ppc_div_lane u_div_x (
        .clk     (clk),
        .en      (pipe_en),
        .num     (num_x),
        .den     (eye_z),
        .neg     (eye_x[31]),
        .quot    (quot_x),
        .clamp   (clamp_x),
        .neg_out (neg_x)
    );

    ppc_div_lane u_div_y (
        .clk     (clk),
        .en      (pipe_en),
        .num     (num_y),
        .den     (eye_z),
        .neg     (eye_y[31]),
        .quot    (quot_y),
        .clamp   (clamp_y),
        .neg_out (neg_y)
    );

    // Back end: clamp, sign and screen offsets, all modulo 2^16.
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] px;
    logic [15:0] py;
    result_t     res;

    assign qx = clamp_x ? CLAMP_QUOT[15:0] : quot_x[15:0];
    assign qy = clamp_y ? CLAMP_QUOT[15:0] : quot_y[15:0];
    assign px = neg_x ? (16'd0 - qx) : qx;
    assign py = neg_y ? (16'd0 - qy) : qy;

    always_comb
    begin
        res.code  = side_reg[LAST].code;
        res.angle = side_reg[LAST].angle;
        if (side_reg[LAST].code == CULL_NONE)
        begin
            res.sx = {1'b0, half_width_reg} + px;
            res.sy = {1'b0, height_reg} - ({1'b0, half_height_reg} + y_shift_reg + py);
        end
        else
        begin
            res.sx = '0;
            res.sy = '0;
        end
    end

    // Output register with a skid entry behind it.
    result_t           out_reg;
    result_t           skid_reg;
    logic [TILE_W-1:0] out_tile_reg;
    logic [TILE_W-1:0] skid_tile_reg;
    logic              take_skid;
    logic              load_out;
    logic              load_skid;

    assign take_skid = skid_valid_reg && !out_stall;
    assign load_out  = !skid_valid_reg && vld_reg[LAST] && (!out_valid_reg || !out_stall);
    assign load_skid = !skid_valid_reg && vld_reg[LAST] && out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_skid)
                skid_valid_reg <= 1'b0;
            else if (load_skid)
                skid_valid_reg <= 1'b1;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!skid_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_skid)
        begin
            out_reg      <= skid_reg;
            out_tile_reg <= skid_tile_reg;
        end
        else if (load_out)
        begin
            out_reg      <= res;
            out_tile_reg <= tile_reg[LAST];
        end
        if (load_skid)
        begin
            skid_reg      <= res;
            skid_tile_reg <= tile_reg[LAST];
        end
    end

    assign out_valid = out_valid_reg;
    assign cull_code = out_reg.code;
    assign screen_x  = out_reg.sx;
    assign screen_y  = out_reg.sy;
    assign angle_out = out_reg.angle;
    assign tile_out  = out_tile_reg;

    `PPC_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg,
        "skid entry holds an item while the output register is empty")
    `PPC_ASSERT_NOW(a_culled_zero, clk, rst_n, out_valid && (cull_code != CULL_NONE),
        (screen_x == 16'sd0) && (screen_y == 16'sd0), "culled item carries screen values")
    `PPC_ASSERT_NOW(a_code_legal, clk, rst_n, out_valid,
        (cull_code == CULL_NONE) || (cull_code == CULL_X) || (cull_code == CULL_Y),
        "illegal cull code on output")
    `PPC_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_reg && !out_stall,
        !skid_valid_reg && out_valid_reg, "skid entry not moved into the output register")

endmodule
